/* rtl/xsv_pkg.sv */
// shared types, constants and the exponential threshold table of the variate source
// depends on nothing
package xsv_pkg;

  localparam int unsigned SHIFT_A   = 12;
  localparam int unsigned SHIFT_B   = 25;
  localparam int unsigned SHIFT_C   = 27;
  localparam int unsigned EXP_COUNT = 44;
  localparam int unsigned CNT_W     = 6;

  localparam logic [63:0] SCRAMBLE_MULT = 64'h2545F4914F6CDD1D;
  localparam logic [63:0] THIRD_LOW     = 64'd6148914691236517205;
  localparam logic [63:0] THIRD_HIGH    = 64'd12297829382473034410;

  typedef enum logic [3:0] {
    K_RAW    = 4'd0,
    K_COIN   = 4'd1,
    K_THREE  = 4'd2,
    K_FOUR   = 4'd3,
    K_BYTE   = 4'd4,
    K_WORD32 = 4'd5,
    K_MOD    = 4'd6,
    K_BERN   = 4'd7,
    K_EXP    = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_EVAL,
    B_DIV,
    B_EXP,
    B_OUT
  } back_state_t;

  // one queued request with its already stepped generator state
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] limit;
    logic [63:0] threshold;
    logic [63:0] gen_state;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [63:0] exp_tab_t [EXP_COUNT];

  // exact floor of a 0.128 fixed point value over a small divisor, bit serial
  function automatic logic [127:0] div_small(input logic [127:0] x, input logic [7:0] d);
    logic [127:0] q;
    logic [7:0]   rem;
    q   = '0;
    rem = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[6:0], x[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // thresholds floor(2^64 * e^-(n+1)), from the series of e^-1 in 0.128 fixed point
  function automatic exp_tab_t build_exp_bounds();
    exp_tab_t     tab;
    logic [127:0] t;
    logic [127:0] c;
    logic [127:0] w;
    logic [255:0] p;
    t = {1'b1, 127'b0};
    c = t;
    for (int k = 3; k <= 40; k++) begin
      t = div_small(t, 8'(k));
      if ((k % 2) == 1) c = c - t;
      else              c = c + t;
    end
    w = c;
    tab[0] = w[127:64];
    for (int n = 1; n < EXP_COUNT; n++) begin
      p = {128'b0, w} * {128'b0, c};
      w = p[255:128];
      tab[n] = w[127:64];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_BOUND = build_exp_bounds();

endpackage

/* rtl/xsv_front.sv */
// front part: accepts requests, steps the xorshift state, loads the seed
// depends on xsv_pkg
module xsv_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_kind,
  input  logic [63:0]      in_limit,
  input  logic [63:0]      in_threshold,
  input  logic             cfg_valid,
  input  logic [63:0]      cfg_seed_value,
  input  xsv_pkg::q_stat_t q_stat,
  output logic             q_push,
  output xsv_pkg::q_item_t q_wdata
);

  logic [63:0] state_r;
  logic [63:0] state_nxt;
  logic [63:0] s1;
  logic [63:0] s2;
  logic [63:0] s3;

  assign s1 = state_r ^ (state_r >> xsv_pkg::SHIFT_A);
  assign s2 = s1 ^ (s1 << xsv_pkg::SHIFT_B);
  assign s3 = s2 ^ (s2 >> xsv_pkg::SHIFT_C);

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_wdata.kind      = in_kind;
    q_wdata.limit     = in_limit;
    q_wdata.threshold = in_threshold;
    q_wdata.gen_state = s3;
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_valid) begin
      // an all-zero state would lock up
      state_nxt = (cfg_seed_value == 64'd0) ? 64'd1 : cfg_seed_value;
    end else if (q_push) begin
      state_nxt = s3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 64'd1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/xsv_queue.sv */
// two-entry request queue between the front and back parts
// depends on xsv_pkg
module xsv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xsv_pkg::q_item_t wdata,
  input  logic             pop,
  output xsv_pkg::q_item_t rdata,
  output xsv_pkg::q_stat_t stat
);

  xsv_pkg::q_item_t mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/xsv_back.sv */
// back part: scrambling multiply, variate shaping, serial modulo, result register
// depends on xsv_pkg
module xsv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  xsv_pkg::q_stat_t q_stat,
  input  xsv_pkg::q_item_t q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_result_value
);

  xsv_pkg::back_state_t state_r, state_nxt;
  xsv_pkg::q_item_t     item_r, item_nxt;
  logic [63:0] p0_r, p0_nxt;
  logic [31:0] p1_r, p1_nxt;
  logic [31:0] p2_r, p2_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [xsv_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [xsv_pkg::EXP_COUNT-1:0] lt_r, lt_nxt;
  logic [63:0] res_r, res_nxt;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic [63:0] kz;
  logic [31:0] mult_hi;
  logic [31:0] mult_lo;
  logic [63:0] pa;
  logic [63:0] pb;

  assign out_valid        = (state_r == xsv_pkg::B_OUT);
  assign out_result_value = res_r;
  assign q_pop            = (state_r == xsv_pkg::B_IDLE) && !q_stat.empty;

  assign mult_hi = xsv_pkg::SCRAMBLE_MULT[63:32];
  assign mult_lo = xsv_pkg::SCRAMBLE_MULT[31:0];
  assign pa      = item_r.gen_state[31:0] * mult_hi;
  assign pb      = item_r.gen_state[63:32] * mult_lo;

  assign rem_sh  = {rem_r, z_r[cnt_r]};
  assign rem_sub = rem_sh - {1'b0, item_r.limit};
  assign kz      = ~z_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    z_nxt     = z_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    lt_nxt    = lt_r;
    res_nxt   = res_r;
    case (state_r)
      xsv_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          item_nxt  = q_rdata;
          state_nxt = xsv_pkg::B_MUL;
        end
      end
      xsv_pkg::B_MUL: begin
        // low 64 bits of the product from three 32x32 partials
        p0_nxt    = item_r.gen_state[31:0] * mult_lo;
        p1_nxt    = pa[31:0];
        p2_nxt    = pb[31:0];
        state_nxt = xsv_pkg::B_SUM;
      end
      xsv_pkg::B_SUM: begin
        z_nxt     = p0_r + {p1_r + p2_r, 32'b0};
        state_nxt = xsv_pkg::B_EVAL;
      end
      xsv_pkg::B_EVAL: begin
        state_nxt = xsv_pkg::B_OUT;
        res_nxt   = 64'd0;
        case (item_r.kind)
          xsv_pkg::K_RAW:    res_nxt = z_r;
          xsv_pkg::K_COIN:   res_nxt = {63'b0, z_r[0]};
          xsv_pkg::K_THREE: begin
            if (z_r > xsv_pkg::THIRD_HIGH)     res_nxt = 64'd2;
            else if (z_r > xsv_pkg::THIRD_LOW) res_nxt = 64'd1;
            else                               res_nxt = 64'd0;
          end
          xsv_pkg::K_FOUR:   res_nxt = {62'b0, z_r[63:62]};
          xsv_pkg::K_BYTE:   res_nxt = {56'b0, z_r[7:0]};
          xsv_pkg::K_WORD32: res_nxt = {32'b0, z_r[31:0]};
          xsv_pkg::K_MOD: begin
            if (item_r.limit == 64'd0) begin
              res_nxt = z_r;
            end else begin
              rem_nxt   = 64'd0;
              cnt_nxt   = '1;
              state_nxt = xsv_pkg::B_DIV;
            end
          end
          xsv_pkg::K_BERN:   res_nxt = {63'b0, (z_r < item_r.threshold)};
          xsv_pkg::K_EXP: begin
            for (int n = 0; n < xsv_pkg::EXP_COUNT; n++) begin
              lt_nxt[n] = kz < xsv_pkg::EXP_BOUND[n];
            end
            state_nxt = xsv_pkg::B_EXP;
          end
          default:           res_nxt = 64'd0;
        endcase
      end
      xsv_pkg::B_DIV: begin
        // restoring remainder, one dividend bit per cycle
        rem_nxt = rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_nxt   = rem_nxt;
          state_nxt = xsv_pkg::B_OUT;
        end
      end
      xsv_pkg::B_EXP: begin
        res_nxt   = 64'($countones(lt_r));
        state_nxt = xsv_pkg::B_OUT;
      end
      xsv_pkg::B_OUT: begin
        if (!out_stall) state_nxt = xsv_pkg::B_IDLE;
      end
      default: state_nxt = xsv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xsv_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    z_r    <= z_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    lt_r   <= lt_nxt;
    res_r  <= res_nxt;
  end

endmodule

/* rtl/xorshift64star_variate_source_top.sv */
// top level of the xorshift64* variate source
// depends on xsv_pkg, xsv_front, xsv_queue, xsv_back
//
// each request steps a 64-bit xorshift state (12, 25, 27), scrambles it with a
// 64-bit multiply and shapes the word into the requested kind of variate. the
// front steps the state and queues the transaction in the cycle it is accepted;
// a two-entry queue lets it take two more while the back works. the back pops,
// multiplies in a partial and a sum state, shapes, and holds the result in an
// output state until it is taken; the exponential kind adds a state for its
// 44-way threshold count, and the modulo kind with a nonzero limit adds the
// one-bit-per-cycle remainder loop, which sets the rate for modulo-heavy traffic.
// writing cfg_seed_value reloads the state at once (zero loads one); cfg_ready
// is always high, and writes belong to idle periods only.
module xorshift64star_variate_source_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [63:0] in_limit,
  input  logic [63:0] in_threshold,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed_value
);

  xsv_pkg::q_stat_t q_stat;
  xsv_pkg::q_item_t q_wdata;
  xsv_pkg::q_item_t q_rdata;
  logic             q_push;
  logic             q_pop;

  // seed writes are always taken at once
  assign cfg_ready = 1'b1;

  xsv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_limit       (in_limit),
    .in_threshold   (in_threshold),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_seed_value (cfg_seed_value),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // decouples request intake from the long modulo loop
  xsv_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  xsv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value)
  );

endmodule

/* rtl/xsv_checker.sv */
// port-level checks for the variate source, bound to the top level
// depends on xorshift64star_variate_source_top
module xsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_value,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_value))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("seed write not taken");

endmodule

bind xorshift64star_variate_source_top xsv_checker u_xsv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);

/* dv/tb_xorshift64star_variate_source_top.sv */
// testbench for the xorshift64* variate source: drives requests, seed writes and
// result stalls, and checks every result against its own model of the generator
// depends on xsv_pkg (kind codes and constants) and xorshift64star_variate_source_top
module tb_xorshift64star_variate_source_top;
  timeunit 1ns;
  timeprecision 1ps;

  // expected variates in order, with the generator model that produces them
  class variate_scoreboard;
    logic [63:0] gen_state;
    logic [63:0] exp_limit [44];
    logic [63:0] pending [$];
    int          errors;

    function new();
      gen_state = 64'd1;
      errors    = 0;
      build_limits();
    endfunction

    // floor(2^64 * e^-(n+1)) from the series of e^-1 in 0.128 fixed point
    function void build_limits();
      logic [127:0] term;
      logic [127:0] acc;
      logic [127:0] pw;
      logic [255:0] prod;
      term = {1'b1, 127'b0};
      acc  = term;
      for (int k = 3; k <= 40; k++) begin
        term = term / k;
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      pw = acc;
      exp_limit[0] = pw[127:64];
      for (int n = 1; n < 44; n++) begin
        prod = {128'b0, pw} * {128'b0, acc};
        pw = prod[255:128];
        exp_limit[n] = pw[127:64];
      end
    endfunction

    function void load_seed(logic [63:0] seed);
      gen_state = (seed == 64'd0) ? 64'd1 : seed;
    endfunction

    // step the generator and queue the variate for this request
    function void note_request(logic [3:0] kind, logic [63:0] limit, logic [63:0] thr);
      logic [63:0] s;
      logic [63:0] z;
      logic [63:0] r;
      s = gen_state;
      s = s ^ (s >> 12);
      s = s ^ (s << 25);
      s = s ^ (s >> 27);
      gen_state = s;
      z = s * xsv_pkg::SCRAMBLE_MULT;
      r = '0;
      case (kind)
        xsv_pkg::K_RAW:    r = z;
        xsv_pkg::K_COIN:   r = {63'b0, z[0]};
        xsv_pkg::K_THREE:
          r = (z > xsv_pkg::THIRD_LOW) ?
              ((z > xsv_pkg::THIRD_HIGH) ? 64'd2 : 64'd1) : 64'd0;
        xsv_pkg::K_FOUR:   r = {62'b0, z[63:62]};
        xsv_pkg::K_BYTE:   r = {56'b0, z[7:0]};
        xsv_pkg::K_WORD32: r = {32'b0, z[31:0]};
        xsv_pkg::K_MOD:    r = (limit == 0) ? z : z % limit;
        xsv_pkg::K_BERN:   r = (z < thr) ? 64'd1 : 64'd0;
        xsv_pkg::K_EXP: begin
          for (int n = 0; n < 44; n++) if (~z < exp_limit[n]) r = r + 1;
        end
        default:  r = '0;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: result_value expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_kind = '0;
  logic [63:0] in_limit = '0;
  logic [63:0] in_threshold = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_seed_value = '0;

  variate_scoreboard board = new();
  bit                calm;   // when set neither side idles

  always #10 clk = ~clk;

  xorshift64star_variate_source_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_limit(in_limit), .in_threshold(in_threshold),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_value(out_result_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_seed_value(cfg_seed_value)
  );

  // result side: random stalls, check at each accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_result_value);
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  // one request transaction; valid stays high when the next one follows at once
  task automatic send_request(logic [3:0] kind, logic [63:0] limit, logic [63:0] thr);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_limit     <= limit;
    in_threshold <= thr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(kind, limit, thr);
  endtask

  // drain everything, let the back finish, then load a new seed
  task automatic write_seed(logic [63:0] seed);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_seed_value <= seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.load_seed(seed);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly small moduli so the slow remainder loop shows varied answers
  function automatic logic [63:0] pick_limit();
    case ($urandom_range(3))
      0: return 64'($urandom_range(7));
      1: return 64'($urandom_range(1000));
      2: return rand64() >> $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [3:0] k;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kind, field extremes and the corner cases
    for (int i = 0; i <= 8; i++) send_request(4'(i), '0, '0);
    send_request(xsv_pkg::K_MOD, 64'd1, '0);              // limit one gives zero
    send_request(xsv_pkg::K_MOD, '1, '0);
    send_request(xsv_pkg::K_MOD, 64'd3, '1);
    send_request(xsv_pkg::K_BERN, '0, '1);                 // full probability
    send_request(xsv_pkg::K_BERN, '1, 64'h8000000000000000);
    send_request(4'd9, '1, '1);                            // unused kinds still step
    send_request(4'd15, '0, '0);
    send_request(xsv_pkg::K_EXP, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
    send_request(xsv_pkg::K_EXP, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
    write_seed(64'd0);                                     // zero seed loads one
    send_request(xsv_pkg::K_RAW, '0, '0);
    write_seed('1);
    send_request(xsv_pkg::K_RAW, '0, '0);
    send_request(xsv_pkg::K_EXP, '0, '0);
    write_seed(64'd1);
    send_request(xsv_pkg::K_RAW, '0, '0);

    // random phases, each with its own seed; the third runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      write_seed(ph == 4 ? 64'h8000000000000000 : rand64());
      calm = (ph == 2);
      for (int i = 0; i < 110; i++) begin
        k = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        send_request(k, pick_limit(),
                     $urandom_range(3) == 0 ? rand64() : rand64() >> $urandom_range(63));
      end
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // 572 requests, with stalls, finish well under this
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

/* xorshift64star_variate_source_top.f */
rtl/xsv_pkg.sv
rtl/xsv_front.sv
rtl/xsv_queue.sv
rtl/xsv_back.sv
rtl/xorshift64star_variate_source_top.sv
rtl/xsv_checker.sv
dv/tb_xorshift64star_variate_source_top.sv
